// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation unit checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on the rising edge and switched off while reset is held.
`define PTC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Sampled on the rising edge, also while reset is held.
`define PTC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ptc_pkg.sv -----
// ---------------------------------------------------------------------------
// ptc_pkg
// Types and constants of the pressure and temperature compensation unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEF       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_OFFSET    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LINEAR    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_QUADRATIC = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CUBIC     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CROSS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CROSS_LINEAR    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CROSS_QUADRATIC = 3'd7;

    // Fallback calibration values loaded at reset.
    localparam logic        [23:0] RST_TEMP_COEF       = 24'd843518;
    localparam logic signed [19:0] RST_PRESS_OFFSET    = 20'sd81507;
    localparam logic signed [19:0] RST_PRESS_LINEAR    = -20'sd66011;
    localparam logic signed [15:0] RST_PRESS_QUADRATIC = -16'sd13579;
    localparam logic signed [15:0] RST_PRESS_CUBIC     = -16'sd2154;
    localparam logic signed [15:0] RST_TEMP_CROSS      = -16'sd2115;
    localparam logic signed [15:0] RST_CROSS_LINEAR    = 16'sd1585;
    localparam logic signed [15:0] RST_CROSS_QUADRATIC = 16'sd117;

    // A reading is complete when the upper status nibble is all ones.
    localparam logic [3:0] STATUS_READY = 4'hF;

    // Pressure scale 1/1040384 = 1/(127 * 2^13). The quotient of the
    // division by 127 is found with a reciprocal floor(2^27 / 127).
    localparam logic [20:0] DIV_RECIP = 21'd1056832;
    localparam logic [7:0]  DIV_BASE  = 8'd127;
    localparam logic [26:0] DIV_BIAS  = 27'd63;

    // Depth of the output buffer.
    localparam int BUF_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [33:0] temperature_fixed;
        logic signed [39:0] pressure_fixed;
    } t_out_item;

    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c20;
        logic signed [15:0] c30;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c21;
    } t_coeffs;

    // Scaled readings handed from the front end to the polynomial stages.
    // ps is the pressure in Q30, t_fix the finished temperature.
    typedef struct packed {
        logic signed [23:0] traw;
        logic signed [34:0] ps;
        logic signed [33:0] t_fix;
    } t_scaled;

endpackage

`default_nettype wire

// ----- design/ptc_scale.sv -----
// ---------------------------------------------------------------------------
// ptc_scale
// Front end: status check, pressure scaling by 1/127 and temperature result.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ptc_pkg::t_in_item i_item,
    input  ptc_pkg::t_coeffs  i_coef,
    output logic              o_valid,
    output ptc_pkg::t_scaled  o_item
);
    import ptc_pkg::*;

    // Stage 1 ---------------------------------------------------------------
    logic               n_s1_valid;
    logic               n_s1_neg;
    logic        [23:0] n_s1_mag;
    logic        [26:0] n_s1_x;
    logic        [47:0] n_s1_divp;
    logic signed [23:0] w_traw;
    logic signed [35:0] w_c1t;
    logic signed [36:0] n_s1_tsum;

    logic               r_s1_valid;
    logic               r_s1_neg;
    logic        [23:0] r_s1_mag;
    logic        [26:0] r_s1_x;
    logic        [47:0] r_s1_divp;
    logic signed [23:0] r_s1_traw;
    logic signed [36:0] r_s1_tsum;

    // Stage 2 ---------------------------------------------------------------
    logic        [20:0] w_q0;
    logic        [27:0] w_rem;
    logic        [20:0] n_s2_qd;
    logic signed [36:0] w_tround;
    logic signed [33:0] n_s2_tfix;

    logic               r_s2_valid;
    logic               r_s2_neg;
    logic        [23:0] r_s2_mag;
    logic        [20:0] r_s2_qd;
    logic signed [23:0] r_s2_traw;
    logic signed [33:0] r_s2_tfix;

    // Stage 3 ---------------------------------------------------------------
    logic        [33:0] w_pmag;
    logic signed [34:0] n_s3_ps;

    logic               r_s3_valid;
    logic signed [34:0] r_s3_ps;
    logic signed [23:0] r_s3_traw;
    logic signed [33:0] r_s3_tfix;

    // The pressure scale works on the magnitude m: with 2^17 = 1032*127 + 8,
    // round(m * 2^17 / 127) = 1032*m + floor((8*m + 63) / 127).
    always_comb begin
        n_s1_valid = i_valid && (i_item.status_byte[7:4] == STATUS_READY);
        n_s1_neg   = i_item.raw_pressure[23];
        n_s1_mag   = n_s1_neg ? (~i_item.raw_pressure + 24'd1) : i_item.raw_pressure;
        n_s1_x     = {n_s1_mag, 3'b000} + DIV_BIAS;
        n_s1_divp  = 48'(n_s1_x) * 48'(DIV_RECIP);
        w_traw     = $signed(i_item.raw_temperature);
        w_c1t      = i_coef.c1 * w_traw;
        n_s1_tsum  = 37'(w_c1t) + (37'(i_coef.c0) <<< 18);
    end

    // The reciprocal estimate is low by at most one; the remainder fixes it.
    always_comb begin
        w_q0      = r_s1_divp[47:27];
        w_rem     = {1'b0, r_s1_x} - ({w_q0, 7'd0} - {7'd0, w_q0});
        n_s2_qd   = w_q0 + {20'd0, (w_rem >= {20'd0, DIV_BASE})};
        // Round half away from zero on the division by 8.
        w_tround  = r_s1_tsum + (r_s1_tsum[36] ? 37'sd3 : 37'sd4);
        n_s2_tfix = w_tround[36:3];
    end

    always_comb begin
        w_pmag  = {r_s2_mag, 10'd0} + {7'd0, r_s2_mag, 3'd0} + {13'd0, r_s2_qd};
        n_s3_ps = r_s2_neg ? -$signed({1'b0, w_pmag}) : $signed({1'b0, w_pmag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_neg  <= n_s1_neg;
            r_s1_mag  <= n_s1_mag;
            r_s1_x    <= n_s1_x;
            r_s1_divp <= n_s1_divp;
            r_s1_traw <= w_traw;
            r_s1_tsum <= n_s1_tsum;

            r_s2_neg  <= r_s1_neg;
            r_s2_mag  <= r_s1_mag;
            r_s2_qd   <= n_s2_qd;
            r_s2_traw <= r_s1_traw;
            r_s2_tfix <= n_s2_tfix;

            r_s3_ps   <= n_s3_ps;
            r_s3_traw <= r_s2_traw;
            r_s3_tfix <= r_s2_tfix;
        end
    end

    always_comb begin
        o_valid      = r_s3_valid;
        o_item.traw  = r_s3_traw;
        o_item.ps    = r_s3_ps;
        o_item.t_fix = r_s3_tfix;
    end

endmodule

`default_nettype wire

// ----- design/ptc_poly.sv -----
// ---------------------------------------------------------------------------
// ptc_poly
// Pressure polynomial in Q30, evaluated over eight register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_poly (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ptc_pkg::t_scaled   i_item,
    input  ptc_pkg::t_coeffs   i_coef,
    output logic               o_valid,
    output ptc_pkg::t_out_item o_item
);
    import ptc_pkg::*;

    // Valid bits of stages 4 to 11.
    logic [7:0] r_vld;

    // Stage 4: a = c20 + c30*ps, q = c11 + c21*ps, traw*ps, c01*traw.
    logic signed [50:0] w_c30ps;
    logic signed [50:0] w_c21ps;
    logic signed [49:0] n_s4_a;
    logic signed [49:0] n_s4_q;
    logic signed [58:0] n_s4_tpp;
    logic signed [39:0] n_s4_cts;
    logic signed [49:0] r_s4_a;
    logic signed [49:0] r_s4_q;
    logic signed [58:0] r_s4_tpp;
    logic signed [39:0] r_s4_cts;
    logic signed [34:0] r_s4_ps;
    logic signed [33:0] r_s4_tfix;

    // Stage 5: round ts*ps back to Q30, split ps*a into two partial products.
    logic signed [58:0] w_tpp_rnd;
    logic signed [39:0] n_s5_tp;
    logic signed [60:0] n_s5_pa_lo;
    logic signed [59:0] n_s5_pa_hi;
    logic signed [39:0] r_s5_tp;
    logic signed [60:0] r_s5_pa_lo;
    logic signed [59:0] r_s5_pa_hi;
    logic               r_s5_pa_neg;
    logic signed [49:0] r_s5_q;
    logic signed [39:0] r_s5_cts;
    logic signed [34:0] r_s5_ps;
    logic signed [33:0] r_s5_tfix;

    // Stage 6: combine ps*a with rounding, split tp*q.
    logic signed [85:0] w_pa;
    logic signed [55:0] n_s6_par;
    logic signed [65:0] n_s6_tq_lo;
    logic signed [64:0] n_s6_tq_hi;
    logic signed [55:0] r_s6_par;
    logic signed [65:0] r_s6_tq_lo;
    logic signed [64:0] r_s6_tq_hi;
    logic               r_s6_tq_neg;
    logic signed [39:0] r_s6_cts;
    logic signed [34:0] r_s6_ps;
    logic signed [33:0] r_s6_tfix;

    // Stage 7: b = c10 + rnd(ps*a), combine tp*q with rounding.
    logic signed [52:0] n_s7_b;
    logic signed [89:0] w_tq;
    logic signed [59:0] n_s7_tqr;
    logic signed [52:0] r_s7_b;
    logic signed [59:0] r_s7_tqr;
    logic signed [39:0] r_s7_cts;
    logic signed [34:0] r_s7_ps;
    logic signed [33:0] r_s7_tfix;

    // Stage 8: split ps*b, sum the terms that need no product.
    logic signed [62:0] n_s8_pb_lo;
    logic signed [60:0] n_s8_pb_hi;
    logic signed [57:0] n_s8_acc;
    logic signed [62:0] r_s8_pb_lo;
    logic signed [60:0] r_s8_pb_hi;
    logic               r_s8_pb_neg;
    logic signed [57:0] r_s8_acc;
    logic signed [33:0] r_s8_tfix;

    // Stage 9 to 11: finish ps*b, total sum, final rounding to 1/256 Pa.
    logic signed [87:0] w_pb;
    logic signed [57:0] n_s9_pbr;
    logic signed [57:0] r_s9_pbr;
    logic signed [57:0] r_s9_acc;
    logic signed [33:0] r_s9_tfix;
    logic signed [57:0] r_s10_sum;
    logic signed [33:0] r_s10_tfix;
    logic signed [57:0] w_sum_rnd;
    logic signed [39:0] n_s11_p;
    logic signed [39:0] r_s11_p;
    logic signed [33:0] r_s11_tfix;

    always_comb begin
        w_c30ps  = i_coef.c30 * i_item.ps;
        w_c21ps  = i_coef.c21 * i_item.ps;
        n_s4_a   = (50'(i_coef.c20) <<< 30) + 50'(w_c30ps);
        n_s4_q   = (50'(i_coef.c11) <<< 30) + 50'(w_c21ps);
        n_s4_tpp = i_item.traw * i_item.ps;
        n_s4_cts = i_coef.c01 * i_item.traw;
    end

    // ts = traw * 2^11, so rnd(ts*ps / 2^30) is traw*ps rounded by 2^19.
    // Each rounding adds half an LSB, or one less for a negative product.
    always_comb begin
        w_tpp_rnd  = r_s4_tpp + (r_s4_tpp[58] ? 59'sd262143 : 59'sd262144);
        n_s5_tp    = w_tpp_rnd[58:19];
        n_s5_pa_lo = r_s4_ps * $signed({1'b0, r_s4_a[24:0]});
        n_s5_pa_hi = r_s4_ps * $signed(r_s4_a[49:25]);
    end

    always_comb begin
        w_pa       = (86'(r_s5_pa_hi) <<< 25) + 86'(r_s5_pa_lo)
                   + (r_s5_pa_neg ? 86'sd536870911 : 86'sd536870912);
        n_s6_par   = w_pa[85:30];
        n_s6_tq_lo = r_s5_tp * $signed({1'b0, r_s5_q[24:0]});
        n_s6_tq_hi = r_s5_tp * $signed(r_s5_q[49:25]);
    end

    always_comb begin
        n_s7_b   = (53'(i_coef.c10) <<< 30) + 53'(r_s6_par);
        w_tq     = (90'(r_s6_tq_hi) <<< 25) + 90'(r_s6_tq_lo)
                 + (r_s6_tq_neg ? 90'sd536870911 : 90'sd536870912);
        n_s7_tqr = w_tq[89:30];
    end

    always_comb begin
        n_s8_pb_lo = r_s7_ps * $signed({1'b0, r_s7_b[26:0]});
        n_s8_pb_hi = r_s7_ps * $signed(r_s7_b[52:27]);
        n_s8_acc   = (58'(i_coef.c00) <<< 30) + (58'(r_s7_cts) <<< 11) + 58'(r_s7_tqr);
    end

    always_comb begin
        w_pb      = (88'(r_s8_pb_hi) <<< 27) + 88'(r_s8_pb_lo)
                  + (r_s8_pb_neg ? 88'sd536870911 : 88'sd536870912);
        n_s9_pbr  = w_pb[87:30];
        w_sum_rnd = r_s10_sum + (r_s10_sum[57] ? 58'sd2097151 : 58'sd2097152);
        n_s11_p   = 40'($signed(w_sum_rnd[57:22]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_a      <= n_s4_a;
            r_s4_q      <= n_s4_q;
            r_s4_tpp    <= n_s4_tpp;
            r_s4_cts    <= n_s4_cts;
            r_s4_ps     <= i_item.ps;
            r_s4_tfix   <= i_item.t_fix;

            r_s5_tp     <= n_s5_tp;
            r_s5_pa_lo  <= n_s5_pa_lo;
            r_s5_pa_hi  <= n_s5_pa_hi;
            r_s5_pa_neg <= r_s4_ps[34] ^ r_s4_a[49];
            r_s5_q      <= r_s4_q;
            r_s5_cts    <= r_s4_cts;
            r_s5_ps     <= r_s4_ps;
            r_s5_tfix   <= r_s4_tfix;

            r_s6_par    <= n_s6_par;
            r_s6_tq_lo  <= n_s6_tq_lo;
            r_s6_tq_hi  <= n_s6_tq_hi;
            r_s6_tq_neg <= r_s5_tp[39] ^ r_s5_q[49];
            r_s6_cts    <= r_s5_cts;
            r_s6_ps     <= r_s5_ps;
            r_s6_tfix   <= r_s5_tfix;

            r_s7_b      <= n_s7_b;
            r_s7_tqr    <= n_s7_tqr;
            r_s7_cts    <= r_s6_cts;
            r_s7_ps     <= r_s6_ps;
            r_s7_tfix   <= r_s6_tfix;

            r_s8_pb_lo  <= n_s8_pb_lo;
            r_s8_pb_hi  <= n_s8_pb_hi;
            r_s8_pb_neg <= r_s7_ps[34] ^ r_s7_b[52];
            r_s8_acc    <= n_s8_acc;
            r_s8_tfix   <= r_s7_tfix;

            r_s9_pbr    <= n_s9_pbr;
            r_s9_acc    <= r_s8_acc;
            r_s9_tfix   <= r_s8_tfix;

            r_s10_sum   <= r_s9_pbr + r_s9_acc;
            r_s10_tfix  <= r_s9_tfix;

            r_s11_p     <= n_s11_p;
            r_s11_tfix  <= r_s10_tfix;
        end
    end

    always_comb begin
        o_valid                  = r_vld[7];
        o_item.temperature_fixed = r_s11_tfix;
        o_item.pressure_fixed    = r_s11_p;
    end

endmodule

`default_nettype wire

// ----- design/ptc_outbuf.sv -----
// ---------------------------------------------------------------------------
// ptc_outbuf
// Two-entry result buffer between the pipeline and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ptc_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_ready,
    output ptc_pkg::t_out_item o_item
);
    import ptc_pkg::*;

    localparam int PTR_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    t_out_item        r_mem [BUF_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(BUF_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/pressure_temperature_compensation_unit.sv -----
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Barometric sensor compensation: raw pressure and temperature readings in,
// calibrated fixed-point temperature and pressure out.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
//  out      output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One input transfer per cycle while o_in_ready is high; eleven pipeline
//  stages feed a two-entry output buffer. Items whose status nibble is not
//  ready leave no result. o_in_ready drops only while both buffer entries
//  hold results; the whole pipeline then holds. Reset is synchronous and
//  loads the default calibration; o_cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ptc_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ptc_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ptc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ptc_pkg::*;

    logic        [23:0] r_temp_coef;
    logic signed [19:0] r_press_offset;
    logic signed [19:0] r_press_linear;
    logic signed [15:0] r_press_quadratic;
    logic signed [15:0] r_press_cubic;
    logic signed [15:0] r_temp_cross;
    logic signed [15:0] r_cross_linear;
    logic signed [15:0] r_cross_quadratic;

    t_coeffs   w_coef;
    logic      w_en;
    logic      w_full;
    logic      w_scaled_valid;
    t_scaled   w_scaled;
    logic      w_poly_valid;
    t_out_item w_poly_item;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !w_full;
    assign o_in_ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coef       <= RST_TEMP_COEF;
            r_press_offset    <= RST_PRESS_OFFSET;
            r_press_linear    <= RST_PRESS_LINEAR;
            r_press_quadratic <= RST_PRESS_QUADRATIC;
            r_press_cubic     <= RST_PRESS_CUBIC;
            r_temp_cross      <= RST_TEMP_CROSS;
            r_cross_linear    <= RST_CROSS_LINEAR;
            r_cross_quadratic <= RST_CROSS_QUADRATIC;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEMP_COEF:       r_temp_coef       <= i_cfg_data;
                REG_PRESS_OFFSET:    r_press_offset    <= i_cfg_data[19:0];
                REG_PRESS_LINEAR:    r_press_linear    <= i_cfg_data[19:0];
                REG_PRESS_QUADRATIC: r_press_quadratic <= i_cfg_data[15:0];
                REG_PRESS_CUBIC:     r_press_cubic     <= i_cfg_data[15:0];
                REG_TEMP_CROSS:      r_temp_cross      <= i_cfg_data[15:0];
                REG_CROSS_LINEAR:    r_cross_linear    <= i_cfg_data[15:0];
                REG_CROSS_QUADRATIC: r_cross_quadratic <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_coef.c0  = $signed(r_temp_coef[23:12]);
        w_coef.c1  = $signed(r_temp_coef[11:0]);
        w_coef.c00 = r_press_offset;
        w_coef.c10 = r_press_linear;
        w_coef.c20 = r_press_quadratic;
        w_coef.c30 = r_press_cubic;
        w_coef.c01 = r_temp_cross;
        w_coef.c11 = r_cross_linear;
        w_coef.c21 = r_cross_quadratic;
    end

    ptc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_coef  (w_coef),
        .o_valid (w_scaled_valid),
        .o_item  (w_scaled)
    );

    ptc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_scaled_valid),
        .i_item  (w_scaled),
        .i_coef  (w_coef),
        .o_valid (w_poly_valid),
        .o_item  (w_poly_item)
    );

    ptc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_poly_valid),
        .i_item  (w_poly_item),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- design/ptc_checker.sv -----
// ---------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input ptc_pkg::t_out_item              o_out_data
);
    import ptc_pkg::*;

    // A result offered and not taken stays offered.
    `PTC_ASSERT_RST(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "output valid dropped before transfer")

    // A result offered and not taken keeps its value.
    `PTC_ASSERT_RST(a_out_data_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data), "output payload changed while stalled")

    // The input side only backs up while results wait at the output.
    `PTC_ASSERT_RST(a_stall_has_result, i_clk, i_rst_n, !o_in_ready |-> o_out_valid, "input stalled with no result waiting")

    // Reset empties the result buffer and opens the input.
    `PTC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready), "block not idle after reset")

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (.*);

`default_nettype wire

// ----- tb/pressure_temperature_compensation_unit_tb.sv -----
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_unit_tb
// Self-checking regression of the compensation unit. A directed table and
// random readings are sent under several calibration sets. Each result is
// compared field by field against a table value or a fixed-point predictor
// of the compensation polynomials. The output sees random back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam realtime     CLK_PERIOD      = 10.0;
    localparam int          RESET_CYCLES    = 9;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 143;
    localparam int          DRAIN_CYCLES    = 32;
    localparam int          SETTLE_LIMIT    = 5000;
    localparam int unsigned LONG_GAP        = 30;
    localparam int unsigned LONG_STALL      = 40;
    localparam int          LONG_HOLD       = 300;
    localparam int          CYCLE_LIMIT     = 600000;

    typedef logic [7:0][CFG_DATA_W-1:0] t_cal_set;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_FIXED,
        ROW_NONE
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_in_item  item;
        t_out_item fixed;
    } t_directed_row;

    // Default calibration with both readings at zero: T = c0/2, P = c00.
    localparam t_out_item RESET_ZERO_RESULT = '{34'sd6717440, 40'sd20865792};
    localparam t_out_item NO_FIXED          = '0;

    localparam int NUM_DIRECTED = 22;
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{ROW_FIXED, '{8'hF0, 24'h000000, 24'h000000}, RESET_ZERO_RESULT},
        '{ROW_FIXED, '{8'hFF, 24'h000000, 24'h000000}, RESET_ZERO_RESULT},
        '{ROW_NONE,  '{8'h00, 24'h000000, 24'h000000}, NO_FIXED},
        '{ROW_NONE,  '{8'hEF, 24'h7FFFFF, 24'h7FFFFF}, NO_FIXED},
        '{ROW_NONE,  '{8'h7F, 24'h800000, 24'h800000}, NO_FIXED},
        '{ROW_NONE,  '{8'h1F, 24'h123456, 24'h654321}, NO_FIXED},
        '{ROW_MODEL, '{8'hF0, 24'h7FFFFF, 24'h000000}, NO_FIXED},
        '{ROW_MODEL, '{8'hF0, 24'h800000, 24'h000000}, NO_FIXED},
        '{ROW_MODEL, '{8'hF0, 24'h000000, 24'h7FFFFF}, NO_FIXED},
        '{ROW_MODEL, '{8'hF0, 24'h000000, 24'h800000}, NO_FIXED},
        '{ROW_MODEL, '{8'hFF, 24'h7FFFFF, 24'h7FFFFF}, NO_FIXED},
        '{ROW_MODEL, '{8'hFF, 24'h800000, 24'h800000}, NO_FIXED},
        '{ROW_MODEL, '{8'hFF, 24'h7FFFFF, 24'h800000}, NO_FIXED},
        '{ROW_MODEL, '{8'hFF, 24'h800000, 24'h7FFFFF}, NO_FIXED},
        '{ROW_MODEL, '{8'hF5, 24'hFFFFFF, 24'hFFFFFF}, NO_FIXED},
        '{ROW_MODEL, '{8'hFA, 24'h000001, 24'h000001}, NO_FIXED},
        '{ROW_MODEL, '{8'hF3, 24'h00007F, 24'h000040}, NO_FIXED},
        '{ROW_MODEL, '{8'hFC, 24'hFFFF81, 24'hFFFFC0}, NO_FIXED},
        '{ROW_MODEL, '{8'hF7, 24'hAAAAAA, 24'h555555}, NO_FIXED},
        '{ROW_MODEL, '{8'hF8, 24'h555555, 24'hAAAAAA}, NO_FIXED},
        '{ROW_NONE,  '{8'hBF, 24'h7FFFFF, 24'h000000}, NO_FIXED},
        '{ROW_NONE,  '{8'hDF, 24'h000000, 24'h7FFFFF}, NO_FIXED}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    t_cal_set  cal_reg;
    t_out_item pending_results [$];
    int        results_checked  = 0;
    int        readings_sent    = 0;
    int        readings_dropped = 0;
    int        mismatch_count   = 0;
    int        cycle_count      = 0;
    bit        steady_flow      = 1'b0;
    bit        hold_req         = 1'b0;

    pressure_temperature_compensation_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_cal_set default_calibration();
        t_cal_set cal;
        cal = '0;
        cal[REG_TEMP_COEF]       = RST_TEMP_COEF;
        cal[REG_PRESS_OFFSET]    = 24'(RST_PRESS_OFFSET);
        cal[REG_PRESS_LINEAR]    = 24'(RST_PRESS_LINEAR);
        cal[REG_PRESS_QUADRATIC] = 24'(RST_PRESS_QUADRATIC);
        cal[REG_PRESS_CUBIC]     = 24'(RST_PRESS_CUBIC);
        cal[REG_TEMP_CROSS]      = 24'(RST_TEMP_CROSS);
        cal[REG_CROSS_LINEAR]    = 24'(RST_CROSS_LINEAR);
        cal[REG_CROSS_QUADRATIC] = 24'(RST_CROSS_QUADRATIC);
        return cal;
    endfunction

    // Divide by 2^sh rounding to nearest, ties away from zero, and limit the
    // magnitude to the signed 64-bit range.
    function automatic logic signed [63:0] round_shift(logic signed [127:0] v,
                                                       int unsigned sh);
        logic [127:0] mag;
        logic [127:0] r;
        mag = v[127] ? -v : v;
        r = (mag >> sh) + ((mag >> (sh - 1)) & 128'd1);
        if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
        return v[127] ? -r[63:0] : r[63:0];
    endfunction

    function automatic logic signed [127:0] mul_q30(logic signed [127:0] a,
                                                    logic signed [127:0] b);
        return 128'(round_shift(a * b, 30));
    endfunction

    function automatic logic signed [63:0] saturate(logic signed [63:0] v,
                                                    int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Returns 0 when the reading is not complete and no result follows.
    function automatic bit compensate_reading(input t_in_item item,
                                              output t_out_item result);
        logic signed [127:0] c0, c1, c00, c10, c20, c30, c01, c11, c21;
        logic signed [127:0] praw, traw, ps, ts, a, b, q, s;
        logic signed [127:0] one_q30;
        logic [127:0]        pmag;
        logic signed [63:0]  temp_fix;
        logic signed [63:0]  press_fix;
        result = '0;
        if (item.status_byte[7:4] != STATUS_READY) return 1'b0;
        c0  = 128'($signed(cal_reg[REG_TEMP_COEF][23:12]));
        c1  = 128'($signed(cal_reg[REG_TEMP_COEF][11:0]));
        c00 = 128'($signed(cal_reg[REG_PRESS_OFFSET][19:0]));
        c10 = 128'($signed(cal_reg[REG_PRESS_LINEAR][19:0]));
        c20 = 128'($signed(cal_reg[REG_PRESS_QUADRATIC][15:0]));
        c30 = 128'($signed(cal_reg[REG_PRESS_CUBIC][15:0]));
        c01 = 128'($signed(cal_reg[REG_TEMP_CROSS][15:0]));
        c11 = 128'($signed(cal_reg[REG_CROSS_LINEAR][15:0]));
        c21 = 128'($signed(cal_reg[REG_CROSS_QUADRATIC][15:0]));
        praw = 128'($signed(item.raw_pressure));
        traw = 128'($signed(item.raw_temperature));
        one_q30 = 128'sd1 <<< 30;

        temp_fix = round_shift(c0 * 262144 + c1 * traw, 3);

        // Pressure scale is 1/(127 * 2^13), so Q30 needs 2^17/127, rounded.
        pmag = ((praw[127] ? -praw : praw) << 17) + 128'd63;
        pmag = pmag / 128'd127;
        ps = praw[127] ? -$signed(pmag) : $signed(pmag);
        ts = traw * 2048;

        a = c20 * one_q30 + c30 * ps;
        b = c10 * one_q30 + mul_q30(ps, a);
        q = c11 * one_q30 + c21 * ps;
        s = c00 * one_q30 + mul_q30(ps, b) + c01 * ts + mul_q30(mul_q30(ts, ps), q);
        press_fix = round_shift(s, 22);

        result.temperature_fixed = 34'(saturate(temp_fix, 34));
        result.pressure_fixed    = 40'(saturate(press_fix, 40));
        return 1'b1;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned pick_idle(int unsigned longest);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(longest, 11);
    endfunction

    function automatic logic [23:0] pick_reading();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'hFFFFFF;
            4: return 24'($signed($urandom_range(511)) - 256);
            default: return 24'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_reading(input t_in_item item, input t_row_kind kind,
                                input t_out_item fixed);
        t_out_item   predicted;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        readings_sent++;
        case (kind)
            ROW_FIXED: pending_results.push_back(fixed);
            ROW_MODEL: begin
                if (compensate_reading(item, predicted)) pending_results.push_back(predicted);
                else readings_dropped++;
            end
            default: readings_dropped++;
        endcase
        @(negedge i_clk);
        gap = steady_flow ? 0 : pick_idle(LONG_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stops offering readings until every expected result has been seen,
    // then lets items that leave no result run out of the pipeline.
    task automatic settle_pipeline();
        int waited;
        i_in_valid <= 1'b0;
        for (waited = 0; waited < SETTLE_LIMIT && pending_results.size() != 0; waited++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_calibration(input t_cal_set cal);
        int i;
        for (i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= i[CFG_INDEX_W-1:0];
            i_cfg_data  <= cal[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            cal_reg[i] = cal[i];
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure, with one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (steady_flow) begin
                i_out_ready <= 1'b1;
            end else if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_idle(LONG_STALL);
                if (stall_left != 0) begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: temperature_fixed %0d, pressure_fixed %0d",
                       o_out_data.temperature_fixed, o_out_data.pressure_fixed);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.temperature_fixed !== want.temperature_fixed) begin
                    $error("temperature_fixed mismatch: expected %0d, actual %0d",
                           want.temperature_fixed, o_out_data.temperature_fixed);
                    mismatch_count++;
                end
                if (o_out_data.pressure_fixed !== want.pressure_fixed) begin
                    $error("pressure_fixed mismatch: expected %0d, actual %0d",
                           want.pressure_fixed, o_out_data.pressure_fixed);
                    mismatch_count++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pressure_temperature_compensation_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int        phase;
        int        row;
        int        n;
        t_cal_set  cal;
        t_in_item  item;

        cal_reg = default_calibration();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) begin
                for (row = 0; row < NUM_DIRECTED; row++)
                    send_reading(DIRECTED_ROWS[row].item, DIRECTED_ROWS[row].kind,
                                 DIRECTED_ROWS[row].fixed);
            end else begin
                case (phase)
                    1: cal = '0;
                    2: begin
                        cal = '0;
                        cal[REG_TEMP_COEF]       = {12'h7FF, 12'h7FF};
                        cal[REG_PRESS_OFFSET]    = 24'h07FFFF;
                        cal[REG_PRESS_LINEAR]    = 24'h07FFFF;
                        cal[REG_PRESS_QUADRATIC] = 24'h007FFF;
                        cal[REG_PRESS_CUBIC]     = 24'h007FFF;
                        cal[REG_TEMP_CROSS]      = 24'h007FFF;
                        cal[REG_CROSS_LINEAR]    = 24'h007FFF;
                        cal[REG_CROSS_QUADRATIC] = 24'h007FFF;
                    end
                    3: begin
                        cal = '0;
                        cal[REG_TEMP_COEF]       = {12'h800, 12'h800};
                        cal[REG_PRESS_OFFSET]    = 24'h080000;
                        cal[REG_PRESS_LINEAR]    = 24'h080000;
                        cal[REG_PRESS_QUADRATIC] = 24'h008000;
                        cal[REG_PRESS_CUBIC]     = 24'h008000;
                        cal[REG_TEMP_CROSS]      = 24'h008000;
                        cal[REG_CROSS_LINEAR]    = 24'h008000;
                        cal[REG_CROSS_QUADRATIC] = 24'h008000;
                    end
                    // All ones: every coefficient is -1 and the unused upper
                    // bits are set as well.
                    4: cal = '1;
                    5: begin
                        cal = '0;
                        cal[REG_TEMP_COEF]       = {12'h7FF, 12'h800};
                        cal[REG_PRESS_OFFSET]    = 24'hF80000;
                        cal[REG_PRESS_LINEAR]    = 24'h07FFFF;
                        cal[REG_PRESS_QUADRATIC] = 24'h007FFF;
                        cal[REG_PRESS_CUBIC]     = 24'hFF8000;
                        cal[REG_TEMP_CROSS]      = 24'h007FFF;
                        cal[REG_CROSS_LINEAR]    = 24'h008000;
                        cal[REG_CROSS_QUADRATIC] = 24'h007FFF;
                    end
                    9: cal = default_calibration();
                    default: begin
                        for (n = 0; n < 8; n++) cal[n] = 24'($urandom());
                    end
                endcase
                settle_pipeline();
                load_calibration(cal);
            end

            // Phases 1 and 2 run without idling; phase 2 also starts with a
            // long result hold-off so the pipeline fills and stalls input.
            steady_flow = (phase == 1) || (phase == 2);
            if (phase == 2) hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2) settle_pipeline();
                if ($urandom_range(99) < 80)
                    item.status_byte = {STATUS_READY, 4'($urandom_range(15))};
                else
                    item.status_byte = 8'($urandom_range(255));
                item.raw_pressure    = pick_reading();
                item.raw_temperature = pick_reading();
                send_reading(item, ROW_MODEL, NO_FIXED);
            end
            steady_flow = 1'b0;
        end

        settle_pipeline();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("Sent %0d readings (%0d not ready) under %0d calibration sets.",
                 readings_sent, readings_dropped, NUM_PHASES);
        $display("Checked %0d compensated results, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("pressure_temperature_compensation_unit regression: pass");
        end else begin
            $display("pressure_temperature_compensation_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
